FILE: hdl/fpol_pkg.sv
// fpol_pkg: shared types and constants of the fixed pool ordered list
// holds command codes, the item structs and the parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpol_pkg;

  // parameter defaults
  localparam int SLOTS_DEFAULT     = 16;
  localparam int DATA_BITS_DEFAULT = 64;

  // capacity register
  localparam int             CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIRST  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  slot_index;
    logic [63:0] data_word;
  } fpol_req_t;

  // result item
  typedef struct packed {
    logic        ok;
    logic [3:0]  result_slot;
    logic [63:0] result_data;
    logic [4:0]  used_count;
  } fpol_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/fpol_ram.sv
// fpol_ram: simple dual port memory, one write and one registered read per cycle
// holds one link, flag or data array of the pool
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fpol_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/fixed_pool_ordered_list.sv
// fixed_pool_ordered_list: pool of slots on ordered free and used linked lists
// steps from accept to result strobe: add runs link then tail; remove runs unlink,
// append, tail; first reads the head's data; a remove of an unused slot ends in unlink,
// any other rejected item is answered at once. a new item is taken in the cycle its
// predecessor's result shows; link memories (one write port each) set the pace.
// results cannot be stalled by the receiver. reset and every capacity write run a
// clearing pass over every slot, busy meanwhile. depends on fpol_pkg and fpol_ram
`timescale 1ns / 1ps
`default_nettype none

module fixed_pool_ordered_list
  import fpol_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEFAULT,
  parameter int DATA_BITS = DATA_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire fpol_req_t           request,
  output logic                     done,
  output fpol_rsp_t                result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_BITS-1:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL  = LW'(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_LINK,
    ST_ADD_TAIL,
    ST_REM_UNLINK,
    ST_REM_APPEND,
    ST_REM_TAIL,
    ST_FIRST
  } state_t;

  state_t              state;
  logic [SW-1:0]       sweep;
  logic [CAP_BITS-1:0] capacity;
  logic [LW-1:0]       free_head;
  logic [LW-1:0]       free_tail;
  logic [LW-1:0]       used_head;
  logic [LW-1:0]       used_tail;
  logic [LW-1:0]       count_used;
  logic [SW-1:0]       cur_slot;

  // memory ports
  logic                 n_we, p_we, u_we, d_we;
  logic [SW-1:0]        n_waddr, p_waddr, u_waddr, d_waddr;
  logic [LW-1:0]        n_wdata, p_wdata;
  logic                 u_wdata;
  logic [DATA_BITS-1:0] d_wdata;
  logic [SW-1:0]        n_raddr, p_raddr, u_raddr, d_raddr;
  logic [LW-1:0]        n_rdata, p_rdata;
  logic                 u_rdata;
  logic [DATA_BITS-1:0] d_rdata;

  logic          accept;
  logic          slot_ok;
  logic [SW-1:0] req_slot;
  logic [LW-1:0] cap_eff;
  logic [LW-1:0] sweep_ext;
  logic [LW-1:0] sweep_inc;
  logic [LW-1:0] cur_ext;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign slot_ok   = (32'(request.slot_index) < SLOTS);
  assign req_slot  = SW'(request.slot_index);
  assign cap_eff   = (32'(capacity) > SLOTS) ? NIL : LW'(capacity);
  assign sweep_ext = LW'(sweep);
  assign sweep_inc = sweep_ext + LW'(1);
  assign cur_ext   = LW'(cur_slot);

  // read addresses, sampled at the accept edge
  assign n_raddr = (request.command == CMD_ADD) ? free_head[SW-1:0] : req_slot;
  assign p_raddr = req_slot;
  assign u_raddr = req_slot;
  assign d_raddr = used_head[SW-1:0];

  // memory write control per sequencer step
  always_comb begin
    n_we    = 1'b0;
    n_waddr = cur_slot;
    n_wdata = NIL;
    p_we    = 1'b0;
    p_waddr = cur_slot;
    p_wdata = NIL;
    u_we    = 1'b0;
    u_waddr = cur_slot;
    u_wdata = 1'b0;
    d_we    = 1'b0;
    d_waddr = free_head[SW-1:0];
    d_wdata = DATA_BITS'(request.data_word);
    unique case (state)
      ST_CLEAR: begin
        n_we    = 1'b1;
        n_waddr = sweep;
        n_wdata = (sweep_inc < cap_eff) ? sweep_inc : NIL;
        p_we    = 1'b1;
        p_waddr = sweep;
        p_wdata = (sweep_ext < cap_eff && sweep_ext != '0) ? sweep_ext - LW'(1) : NIL;
        u_we    = 1'b1;
        u_waddr = sweep;
        u_wdata = 1'b0;
      end
      ST_IDLE: begin
        // add: link new slot behind the used tail, mark it, store data
        if (accept && request.command == CMD_ADD && free_head != NIL) begin
          p_we    = 1'b1;
          p_waddr = free_head[SW-1:0];
          p_wdata = used_tail;
          u_we    = 1'b1;
          u_waddr = free_head[SW-1:0];
          u_wdata = 1'b1;
          d_we    = 1'b1;
        end
      end
      ST_ADD_LINK: begin
        n_we = 1'b1;
        if (n_rdata != NIL) begin
          p_we    = 1'b1;
          p_waddr = n_rdata[SW-1:0];
          p_wdata = NIL;
        end
      end
      ST_ADD_TAIL: begin
        if (used_tail != NIL) begin
          n_we    = 1'b1;
          n_waddr = used_tail[SW-1:0];
          n_wdata = cur_ext;
        end
      end
      ST_REM_UNLINK: begin
        if (u_rdata) begin
          u_we = 1'b1;
          if (p_rdata != NIL) begin
            n_we    = 1'b1;
            n_waddr = p_rdata[SW-1:0];
            n_wdata = n_rdata;
          end
          if (n_rdata != NIL) begin
            p_we    = 1'b1;
            p_waddr = n_rdata[SW-1:0];
            p_wdata = p_rdata;
          end
        end
      end
      ST_REM_APPEND: begin
        n_we    = 1'b1;
        p_we    = 1'b1;
        p_wdata = free_tail;
      end
      ST_REM_TAIL: begin
        if (free_tail != NIL) begin
          n_we    = 1'b1;
          n_waddr = free_tail[SW-1:0];
          n_wdata = cur_ext;
        end
      end
      ST_FIRST: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, list heads and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep      <= '0;
      capacity   <= CAP_RESET;
      count_used <= '0;
      done       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      capacity   <= cfg_data;
      state      <= ST_CLEAR;
      sweep      <= '0;
      count_used <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + SW'(1);
          if (sweep == LAST) begin
            state     <= ST_IDLE;
            free_head <= (cap_eff != '0) ? '0 : NIL;
            free_tail <= (cap_eff != '0) ? cap_eff - LW'(1) : NIL;
            used_head <= NIL;
            used_tail <= NIL;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur_slot <= req_slot;
            // default: rejected item answered at once
            done                <= 1'b1;
            result.ok           <= 1'b0;
            result.result_slot  <= '0;
            result.result_data  <= '0;
            result.used_count   <= 5'(count_used);
            unique case (request.command)
              CMD_ADD: begin
                if (free_head != NIL) begin
                  done     <= 1'b0;
                  cur_slot <= free_head[SW-1:0];
                  state    <= ST_ADD_LINK;
                end
              end
              CMD_REMOVE: begin
                if (slot_ok) begin
                  done  <= 1'b0;
                  state <= ST_REM_UNLINK;
                end
              end
              CMD_FIRST: begin
                if (used_head != NIL) begin
                  done  <= 1'b0;
                  state <= ST_FIRST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD_LINK: begin
          free_head <= n_rdata;
          if (n_rdata == NIL) begin
            free_tail <= NIL;
          end
          state <= ST_ADD_TAIL;
        end
        ST_ADD_TAIL: begin
          if (used_tail == NIL) begin
            used_head <= cur_ext;
          end
          used_tail          <= cur_ext;
          count_used         <= count_used + LW'(1);
          done               <= 1'b1;
          result.ok          <= 1'b1;
          result.result_slot <= 4'(cur_slot);
          result.result_data <= '0;
          result.used_count  <= 5'(count_used + LW'(1));
          state              <= ST_IDLE;
        end
        ST_REM_UNLINK: begin
          if (u_rdata) begin
            if (p_rdata == NIL) begin
              used_head <= n_rdata;
            end
            if (n_rdata == NIL) begin
              used_tail <= p_rdata;
            end
            state <= ST_REM_APPEND;
          end else begin
            done               <= 1'b1;
            result.ok          <= 1'b0;
            result.result_slot <= '0;
            result.result_data <= '0;
            result.used_count  <= 5'(count_used);
            state              <= ST_IDLE;
          end
        end
        ST_REM_APPEND: begin
          state <= ST_REM_TAIL;
        end
        ST_REM_TAIL: begin
          if (free_tail == NIL) begin
            free_head <= cur_ext;
          end
          free_tail          <= cur_ext;
          count_used         <= count_used - LW'(1);
          done               <= 1'b1;
          result.ok          <= 1'b1;
          result.result_slot <= 4'(cur_slot);
          result.result_data <= '0;
          result.used_count  <= 5'(count_used - LW'(1));
          state              <= ST_IDLE;
        end
        ST_FIRST: begin
          done               <= 1'b1;
          result.ok          <= 1'b1;
          result.result_slot <= 4'(used_head);
          result.result_data <= 64'(d_rdata);
          result.used_count  <= 5'(count_used);
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // link, flag and data memories
  fpol_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  fpol_ram #(.DEPTH(SLOTS), .WIDTH(LW)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  fpol_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_use_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  fpol_ram #(.DEPTH(SLOTS), .WIDTH(DATA_BITS)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // checks
  a_count_in_pool: assert property (@(posedge clk) disable iff (rst)
    count_used <= cap_eff)
    else $error("used count exceeds pool capacity");

  a_free_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> ((free_head == NIL) == (free_tail == NIL)))
    else $error("free list head and tail disagree on empty");

  a_used_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> ((used_head == NIL) == (used_tail == NIL))
                         && ((used_head == NIL) == (count_used == '0)))
    else $error("used list ends disagree with used count");

endmodule

`default_nettype wire
